>>> rtl/core/pvd_pkg.sv
// Package for the patch vertex dedup core: sizes, memory port structs,
// the result word type and its packing helper. No dependencies.
package pvd_pkg;

  localparam int unsigned VertexCapacity = 65536;
  localparam int unsigned PatchListDepth = 1024;
  localparam int unsigned NumCorners     = 3;

  localparam int unsigned VertexW = 16;
  localparam int unsigned TotalW  = 11;
  localparam int unsigned CountW  = 2;
  localparam int unsigned SeenAw  = $clog2(VertexCapacity);
  localparam int unsigned ListAw  = $clog2(PatchListDepth);
  localparam int unsigned FillW   = $clog2(PatchListDepth + 1);

  typedef logic [VertexW-1:0] vertex_t;

  typedef struct packed {
    logic              we;
    logic [SeenAw-1:0] waddr;
    logic              wdata;
    logic [SeenAw-1:0] raddr;
  } seen_req_t;

  typedef struct packed {
    logic              we;
    logic [ListAw-1:0] waddr;
    vertex_t           wdata;
    logic [ListAw-1:0] raddr;
  } list_req_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    vertex_t           vtx0;
    vertex_t           vtx1;
    vertex_t           vtx2;
    logic              done;
    logic [TotalW-1:0] total;
    logic              ovf;
  } result_t;

  function automatic result_t pvd_pack(logic [CountW-1:0] count, vertex_t v0, vertex_t v1,
                                       vertex_t v2, logic done, logic [FillW-1:0] fill,
                                       logic ovf);
    result_t r;
    r.count = count;
    r.vtx0  = v0;
    r.vtx1  = v1;
    r.vtx2  = v2;
    r.done  = done;
    r.total = TotalW'(fill);
    r.ovf   = ovf;
    return r;
  endfunction

endpackage

>>> rtl/core/pvd_if.sv
// Valid/ready channel interfaces for triangle words in and result words out.
// Depends on pvd_pkg.
interface pvd_in_if;
  import pvd_pkg::*;
  logic    valid;
  logic    ready;
  vertex_t corner_a;
  vertex_t corner_b;
  vertex_t corner_c;
  logic    last_in_patch;

  modport source (output valid, corner_a, corner_b, corner_c, last_in_patch, input ready);
  modport sink   (input valid, corner_a, corner_b, corner_c, last_in_patch, output ready);
endinterface

interface pvd_out_if;
  import pvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] new_count;
  vertex_t           new_vertex_0;
  vertex_t           new_vertex_1;
  vertex_t           new_vertex_2;
  logic              patch_done;
  logic [TotalW-1:0] patch_vertex_total;
  logic              list_overflow;

  modport source (output valid, new_count, new_vertex_0, new_vertex_1, new_vertex_2,
                  patch_done, patch_vertex_total, list_overflow, input ready);
  modport sink   (input valid, new_count, new_vertex_0, new_vertex_1, new_vertex_2,
                  patch_done, patch_vertex_total, list_overflow, output ready);
endinterface

>>> rtl/core/pvd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pvd_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/pvd_seq.sv
// Sequencer for the dedup core: checks one corner per cycle against the seen
// bitmap, fills the patch list and walks it back at patch end.
// Depends on pvd_pkg.
module pvd_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pvd_pkg::vertex_t    corner_a_i,
  input  pvd_pkg::vertex_t    corner_b_i,
  input  pvd_pkg::vertex_t    corner_c_i,
  input  logic                last_i,
  output pvd_pkg::seen_req_t  seen_req_o,
  input  logic                seen_rdata_i,
  output pvd_pkg::list_req_t  list_req_o,
  input  pvd_pkg::vertex_t    list_rdata_i,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output pvd_pkg::result_t    res_o
);
  import pvd_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StInit = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StPost = 3'd3;
  localparam logic [2:0] StWalk = 3'd4;

  localparam logic [1:0] LastCorner = 2'(NumCorners - 1);

  logic [2:0]        state_q, state_d;
  logic [SeenAw-1:0] clr_q, clr_d;
  logic [1:0]        k_q, k_d;
  vertex_t           corner_q [NumCorners];
  logic              last_q;
  vertex_t           fresh_q [NumCorners];
  vertex_t           fresh_d [NumCorners];
  logic [CountW-1:0] count_q, count_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic              mark_q, mark_d;
  vertex_t           mark_v_q, mark_v_d;
  logic [FillW-1:0]  walk_q, walk_d;
  logic              pend_q, pend_d;

  vertex_t cur_v;
  logic    in_rng;
  logic    seen_bit;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;
  assign cur_v  = corner_q[k_q];
  assign in_rng = 32'(cur_v) < VertexCapacity;
  // previous corner was marked last cycle; the RAM read returned old data
  assign seen_bit = seen_rdata_i || (mark_q && (cur_v == mark_v_q));

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    k_d        = k_q;
    fresh_d    = fresh_q;
    count_d    = count_q;
    fill_d     = fill_q;
    ovf_d      = ovf_q;
    mark_d     = mark_q;
    mark_v_d   = mark_v_q;
    walk_d     = walk_q;
    pend_d     = 1'b0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o = pvd_pack(count_q, fresh_q[0], fresh_q[1], fresh_q[2], last_q, fill_q, ovf_q);

    seen_req_o.we    = 1'b0;
    seen_req_o.waddr = SeenAw'(cur_v);
    seen_req_o.wdata = 1'b1;
    seen_req_o.raddr = SeenAw'(corner_q[(k_q == LastCorner) ? k_q : k_q + 2'd1]);
    list_req_o.we    = 1'b0;
    list_req_o.waddr = ListAw'(fill_q);
    list_req_o.wdata = cur_v;
    list_req_o.raddr = ListAw'(walk_q);

    case (state_q)
      StInit: begin
        seen_req_o.we    = 1'b1;
        seen_req_o.waddr = clr_q;
        seen_req_o.wdata = 1'b0;
        clr_d = clr_q + 1'b1;
        if (clr_q == SeenAw'(VertexCapacity - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o       = 1'b1;
        seen_req_o.raddr = SeenAw'(corner_a_i);
        if (in_valid_i) begin
          for (int i = 0; i < NumCorners; i++) begin
            fresh_d[i] = '0;
          end
          count_d = '0;
          k_d     = '0;
          mark_d  = 1'b0;
          state_d = StChk;
        end
      end
      StChk: begin
        mark_d = 1'b0;
        if (in_rng && !seen_bit) begin
          for (int i = 0; i < NumCorners; i++) begin
            if (count_q == 2'(i)) begin
              fresh_d[i] = cur_v;
            end
          end
          count_d = count_q + 1'b1;
          if (fill_q < FillW'(PatchListDepth)) begin
            list_req_o.we = 1'b1;
            seen_req_o.we = 1'b1;
            fill_d   = fill_q + 1'b1;
            mark_d   = 1'b1;
            mark_v_d = cur_v;
          end else begin
            ovf_d = 1'b1;
          end
        end
        if (k_q == LastCorner) begin
          walk_d = '0;
          if (out_free_i) begin
            res_valid_o = 1'b1;
            res_o = pvd_pack(count_d, fresh_d[0], fresh_d[1], fresh_d[2], last_q, fill_d,
                             ovf_d);
            state_d = last_q ? StWalk : StIdle;
          end else begin
            state_d = StPost;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StPost: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d = last_q ? StWalk : StIdle;
        end
      end
      StWalk: begin
        // the list read is issued the cycle before the bitmap clear that uses its data
        if (pend_q) begin
          seen_req_o.we    = 1'b1;
          seen_req_o.waddr = SeenAw'(list_rdata_i);
          seen_req_o.wdata = 1'b0;
        end
        if (walk_q < fill_q) begin
          walk_d = walk_q + 1'b1;
          pend_d = 1'b1;
        end else if (!pend_q) begin
          fill_d  = '0;
          ovf_d   = 1'b0;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      clr_q   <= '0;
      k_q     <= '0;
      count_q <= '0;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      mark_q  <= 1'b0;
      walk_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      count_q <= count_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      mark_q  <= mark_d;
      walk_q  <= walk_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fresh_q  <= fresh_d;
    mark_v_q <= mark_v_d;
    if (accept) begin
      corner_q[0] <= corner_a_i;
      corner_q[1] <= corner_b_i;
      corner_q[2] <= corner_c_i;
      last_q      <= last_i;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(PatchListDepth))
    else $error("patch list fill beyond depth");

  a_post_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result posted into a full output register");

  a_three_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 (state_q == StChk && k_q == LastCorner))
    else $error("corner checks did not reach the last corner in three cycles");

  a_walk_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk && seen_req_o.we) |-> (!seen_req_o.wdata && $past(walk_q) < fill_q))
    else $error("bad bitmap write during list walk");

endmodule

>>> rtl/core/patch_vertex_dedup_core.sv
// Patch vertex dedup core: one triangle word in, one result word out.
// After accept, corners are checked one per cycle on the shared bitmap port:
// the accept, then a check of each corner, result registered at the end.
// A patch-closing triangle adds a walk over the patch_vertex_total list entries that clears their bitmap marks.
// After reset all 65536 bitmap entries are cleared before the first accept.
// Depends on pvd_pkg, pvd_if, pvd_ram, pvd_seq.
module patch_vertex_dedup_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  pvd_in_if.sink         in_i,
  pvd_out_if.source      out_o
);
  import pvd_pkg::*;

  seen_req_t seen_req;
  list_req_t list_req;
  logic      seen_rdata;
  vertex_t   list_rdata;
  logic      res_valid;
  result_t   res;
  logic      out_free;
  logic      out_valid_q;
  result_t   out_q;

  assign out_free = !out_valid_q || out_o.ready;

  pvd_ram #(.Width(1), .Depth(VertexCapacity)) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_req.we),
    .waddr_i (seen_req.waddr),
    .wdata_i (seen_req.wdata),
    .raddr_i (seen_req.raddr),
    .rdata_o (seen_rdata)
  );

  pvd_ram #(.Width(VertexW), .Depth(PatchListDepth)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_req.we),
    .waddr_i (list_req.waddr),
    .wdata_i (list_req.wdata),
    .raddr_i (list_req.raddr),
    .rdata_o (list_rdata)
  );

  pvd_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .corner_a_i   (in_i.corner_a),
    .corner_b_i   (in_i.corner_b),
    .corner_c_i   (in_i.corner_c),
    .last_i       (in_i.last_in_patch),
    .seen_req_o   (seen_req),
    .seen_rdata_i (seen_rdata),
    .list_req_o   (list_req),
    .list_rdata_i (list_rdata),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.new_count          = out_q.count;
  assign out_o.new_vertex_0       = out_q.vtx0;
  assign out_o.new_vertex_1       = out_q.vtx1;
  assign out_o.new_vertex_2       = out_q.vtx2;
  assign out_o.patch_done         = out_q.done;
  assign out_o.patch_vertex_total = out_q.total;
  assign out_o.list_overflow      = out_q.ovf;

endmodule

>>> tb/sv/patch_vertex_dedup_core_tb.sv
// Testbench for patch_vertex_dedup_core: random triangle words, large overflow patches,
// random stalls on both channels, checked against an in-bench dedup scoreboard.
// Depends on pvd_pkg, pvd_if and the core RTL.
module patch_vertex_dedup_core_tb;
  import pvd_pkg::*;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ItemsTarget = 1350;
  localparam int unsigned BigPatchTop = 1060;  // vertex offsets walked by a large patch
  localparam int unsigned TimeoutCyc  = 1_200_000;

  // Tracks per-vertex marks and the current patch member list, predicts one
  // result word per triangle and checks results in order.
  class vertex_dedup_scoreboard;
    bit          vertex_marked[VertexCapacity];
    vertex_t     patch_members[$];
    bit          overflowed;
    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned patches_closed;
    int unsigned overflow_patches;

    function void note_triangle(vertex_t a, vertex_t b, vertex_t c, logic last);
      vertex_t     corner[NumCorners];
      vertex_t     fresh[NumCorners];
      int unsigned n;
      result_t     r;
      corner = '{a, b, c};
      fresh  = '{default: '0};
      n      = 0;
      foreach (corner[k]) begin
        if (corner[k] >= VertexCapacity || vertex_marked[corner[k]]) continue;
        fresh[n] = corner[k];
        n++;
        if (patch_members.size() < PatchListDepth) begin
          patch_members = {patch_members, corner[k]};
          vertex_marked[corner[k]] = 1'b1;
        end else begin
          // list full: emitted but never marked, so it shows up again on recurrence
          overflowed = 1'b1;
        end
      end
      r.count = CountW'(n);
      r.vtx0  = fresh[0];
      r.vtx1  = fresh[1];
      r.vtx2  = fresh[2];
      r.done  = last;
      r.total = TotalW'(patch_members.size());
      r.ovf   = overflowed;
      pending_results = {pending_results, r};
      if (last) begin
        foreach (patch_members[i]) vertex_marked[patch_members[i]] = 1'b0;
        patches_closed++;
        if (overflowed) overflow_patches++;
        patch_members.delete();
        overflowed = 1'b0;
      end
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, expected nothing, actual 0x%0h",
                 $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      report_field("new_count", 32'(want.count), 32'(got.count));
      report_field("new_vertex_0", 32'(want.vtx0), 32'(got.vtx0));
      report_field("new_vertex_1", 32'(want.vtx1), 32'(got.vtx1));
      report_field("new_vertex_2", 32'(want.vtx2), 32'(got.vtx2));
      report_field("patch_done", 32'(want.done), 32'(got.done));
      report_field("patch_vertex_total", 32'(want.total), 32'(got.total));
      report_field("list_overflow", 32'(want.ovf), 32'(got.ovf));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pvd_in_if  in_if ();
  pvd_out_if out_if ();

  patch_vertex_dedup_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  vertex_dedup_scoreboard sb = new();

  int unsigned sent;
  bit          src_calm;
  bit          sink_calm;
  vertex_t     shared_pool[32];

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(ClkPeriod * TimeoutCyc);
    $display("FAIL patch_vertex_dedup_core");
    $finish;
  end

  // Mostly short gaps, a few long ones; none at all while calm.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_triangle(vertex_t a, vertex_t b, vertex_t c, logic last);
    int unsigned gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.corner_a      <= a;
    in_if.corner_b      <= b;
    in_if.corner_c      <= c;
    in_if.last_in_patch <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_triangle(a, b, c, last);
    sent++;
    if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
  endtask

  // Walks fresh consecutive vertices past the list depth with some repeats of earlier
  // ones, listed or not, repeats an unlisted one in one triangle, then closes the patch.
  task automatic run_big_patch();
    vertex_t     base;
    vertex_t     c[NumCorners];
    int unsigned k;
    base = vertex_t'($urandom);
    k    = 0;
    while (k < BigPatchTop) begin
      foreach (c[j]) begin
        if (k > 0 && $urandom_range(0, 9) == 0) begin
          c[j] = vertex_t'(base + $urandom_range(0, k - 1));
        end else begin
          c[j] = vertex_t'(base + k);
          k++;
        end
      end
      send_triangle(c[0], c[1], c[2], 1'b0);
    end
    send_triangle(vertex_t'(base + k), vertex_t'(base + k), vertex_t'(base + k), 1'b0);
    send_triangle(vertex_t'(base + k + 1), base, vertex_t'(base + k + 1), 1'b1);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned gap;
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
    end
  end

  always @(posedge clk_i) begin : sample_results
    result_t got;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.count = out_if.new_count;
      got.vtx0  = out_if.new_vertex_0;
      got.vtx1  = out_if.new_vertex_1;
      got.vtx2  = out_if.new_vertex_2;
      got.done  = out_if.patch_done;
      got.total = out_if.patch_vertex_total;
      got.ovf   = out_if.list_overflow;
      sb.check_result(got);
    end
  end

  initial begin
    vertex_t     c[NumCorners];
    vertex_t     local_base;
    int unsigned n;
    int unsigned next_big;
    int unsigned bigs_done;
    int unsigned r;

    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.corner_a      <= '0;
    in_if.corner_b      <= '0;
    in_if.corner_c      <= '0;
    in_if.last_in_patch <= 1'b0;
    sent      = 0;
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    foreach (shared_pool[i]) shared_pool[i] = vertex_t'($urandom);
    shared_pool[0] = '0;
    shared_pool[1] = '1;
    shared_pool[2] = 16'h8000;
    shared_pool[3] = 16'h7fff;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, repeats inside one triangle, reuse across patch ends
    send_triangle(16'h0000, 16'hffff, 16'h5555, 1'b0);
    send_triangle(16'haaaa, 16'h0000, 16'hffff, 1'b0);
    send_triangle(16'h0007, 16'h0007, 16'h0007, 1'b0);
    send_triangle(16'h0008, 16'h0009, 16'h0008, 1'b0);
    send_triangle(16'h0000, 16'hffff, 16'h0007, 1'b1);
    send_triangle(16'h0000, 16'hffff, 16'h0000, 1'b1);
    send_triangle(16'h1234, 16'h1234, 16'h1234, 1'b1);
    send_triangle(16'h0001, 16'h0002, 16'h0001, 1'b0);
    send_triangle(16'h0002, 16'h0003, 16'h0001, 1'b0);
    send_triangle(16'h0003, 16'h0001, 16'h0002, 1'b1);
    send_triangle(16'h0003, 16'h0003, 16'h0004, 1'b0);
    send_triangle(16'hfffe, 16'h0004, 16'hffff, 1'b1);

    // random: mostly short patches, two large ones that run the list past full
    next_big  = 250 + $urandom_range(0, 100);
    bigs_done = 0;
    while (sent < ItemsTarget) begin
      if (bigs_done < 2 && sent >= next_big) begin
        run_big_patch();
        bigs_done++;
        next_big = sent + 150 + $urandom_range(0, 100);
      end else begin
        n          = $urandom_range(1, 12);
        local_base = vertex_t'($urandom);
        for (int unsigned i = 0; i < n; i++) begin
          foreach (c[j]) begin
            r = $urandom_range(0, 9);
            if (r < 4)      c[j] = vertex_t'(local_base + $urandom_range(0, 15));
            else if (r < 7) c[j] = shared_pool[5'($urandom_range(0, 31))];
            else            c[j] = vertex_t'($urandom);
          end
          send_triangle(c[0], c[1], c[2], i == n - 1);
        end
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    // let a closing list walk finish, catching any stray result word
    repeat (1100) @(posedge clk_i);

    $display("Sent %0d triangles, checked %0d result words over %0d closed patches",
             sent, sb.checked, sb.patches_closed);
    $display("%0d patches ran past a full vertex list", sb.overflow_patches);
    if (sb.mismatches == 0) begin
      $display("PASS patch_vertex_dedup_core");
    end else begin
      $display("FAIL patch_vertex_dedup_core");
    end
    $finish;
  end

endmodule
